// ===== src/mhpq_pkg.sv =====
// Package for the min-heap priority queue.
// Holds the sizing constants, the request codes and the sequencer state type; depends on nothing.
package mhpq_pkg;

    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_RM,
        ST_DN,
        ST_DONE
    } t_state;

endpackage

// ===== src/min_heap_priority_queue_top.sv =====
// A request is either an insert of a signed key or a removal of the minimum, and every
// request gives exactly one result transfer. The heap lives in one memory with one write
// port and two registered read ports. An insert climbs one level per step: each step
// compares the parent read in the previous step and fetches the next parent at once. A
// removal that leaves entries behind first fetches the root and the last entry, then sinks
// the entry one level per step, with both children fetched together on the two read ports.
// The next request is accepted as soon as the previous result is in the output register,
// even if the consumer has not yet taken it.
// Depends on mhpq_pkg.
module min_heap_priority_queue_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [mhpq_pkg::DATA_WIDTH-1:0] s_axis_tdata,  // [31:0] value
    input  logic                              s_axis_tuser,  // [0] req_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // [31:0] min_value, [39:32] entry_count
    output logic [1:0]                        m_axis_tuser   // [0] empty_error, [1] full_error
);

    localparam int AW = mhpq_pkg::ADDR_W;
    localparam int CW = mhpq_pkg::CNT_W;
    localparam int DW = mhpq_pkg::DATA_WIDTH;

    logic signed [DW-1:0] r_mem [mhpq_pkg::CAPACITY];

    mhpq_pkg::t_state r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_pos, n_pos;
    logic signed [DW-1:0] r_moving, n_moving;
    logic signed [DW-1:0] r_min, n_min;
    logic                 r_empty, n_empty;
    logic                 r_full, n_full;

    logic                 r_m_tvalid, n_m_tvalid;
    logic [31:0]          r_m_min, n_m_min;
    logic [7:0]           r_m_count, n_m_count;
    logic [1:0]           r_m_flags, n_m_flags;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;
    logic [AW-1:0]        rd_addr_a, rd_addr_b;
    logic signed [DW-1:0] r_rd_a, r_rd_b;

    logic [AW-1:0]        up_pos;
    logic [AW+1:0]        kid_l, kid_r;
    logic                 sel_right;
    logic [AW-1:0]        ckid;
    logic signed [DW-1:0] chosen;
    logic [AW:0]          nk_l, nk_r;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mhpq_pkg::ST_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
        end
        r_pos     <= n_pos;
        r_moving  <= n_moving;
        r_min     <= n_min;
        r_empty   <= n_empty;
        r_full    <= n_full;
        r_m_min   <= n_m_min;
        r_m_count <= n_m_count;
        r_m_flags <= n_m_flags;
    end

    assign up_pos    = AW'((r_pos - AW'(1)) >> 1);
    assign kid_l     = {1'b0, r_pos, 1'b1};
    assign kid_r     = kid_l + (AW+2)'(1);
    assign sel_right = (kid_r < (AW+2)'(r_count)) && (r_rd_a > r_rd_b);
    assign ckid      = sel_right ? kid_r[AW-1:0] : kid_l[AW-1:0];
    assign chosen    = sel_right ? r_rd_b : r_rd_a;
    assign nk_l      = {ckid, 1'b1};
    assign nk_r      = nk_l + (AW+1)'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_moving   = r_moving;
        n_min      = r_min;
        n_empty    = r_empty;
        n_full     = r_full;
        n_m_tvalid = r_m_tvalid && !m_axis_tready;
        n_m_min    = r_m_min;
        n_m_count  = r_m_count;
        n_m_flags  = r_m_flags;
        wr_en      = 1'b0;
        wr_addr    = r_pos;
        wr_data    = r_moving;
        rd_addr_a  = '0;
        rd_addr_b  = '0;

        case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_empty = 1'b0;
                    n_full  = 1'b0;
                    n_min   = '0;
                    if (s_axis_tuser == mhpq_pkg::REQ_INSERT) begin
                        if (r_count >= mhpq_pkg::CAP_COUNT) begin
                            n_full  = 1'b1;
                            n_state = mhpq_pkg::ST_DONE;
                        end else begin
                            n_pos     = r_count[AW-1:0];
                            n_moving  = s_axis_tdata;
                            n_count   = r_count + CW'(1);
                            rd_addr_a = AW'((r_count[AW-1:0] - AW'(1)) >> 1);
                            n_state   = mhpq_pkg::ST_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_empty = 1'b1;
                            n_state = mhpq_pkg::ST_DONE;
                        end else begin
                            rd_addr_a = '0;
                            rd_addr_b = AW'(r_count - CW'(1));
                            n_count   = r_count - CW'(1);
                            n_state   = mhpq_pkg::ST_RM;
                        end
                    end
                end
            end
            mhpq_pkg::ST_UP: begin
                wr_en = 1'b1;
                if (r_pos != '0 && r_rd_a > r_moving) begin
                    wr_data   = r_rd_a;
                    n_pos     = up_pos;
                    rd_addr_a = AW'((up_pos - AW'(1)) >> 1);
                end else begin
                    n_state = mhpq_pkg::ST_DONE;
                end
            end
            mhpq_pkg::ST_RM: begin
                n_min    = r_rd_a;
                n_moving = r_rd_b;
                n_pos    = '0;
                if (r_count == '0) begin
                    n_state = mhpq_pkg::ST_DONE;
                end else begin
                    rd_addr_a = AW'(1);
                    rd_addr_b = AW'(2);
                    n_state   = mhpq_pkg::ST_DN;
                end
            end
            mhpq_pkg::ST_DN: begin
                wr_en = 1'b1;
                if (kid_l < (AW+2)'(r_count) && r_moving > chosen) begin
                    wr_data   = chosen;
                    n_pos     = ckid;
                    rd_addr_a = nk_l[AW-1:0];
                    rd_addr_b = nk_r[AW-1:0];
                end else begin
                    n_state = mhpq_pkg::ST_DONE;
                end
            end
            mhpq_pkg::ST_DONE: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_min    = 32'(r_min);
                    n_m_count  = 8'(r_count);
                    n_m_flags  = {r_full, r_empty};
                    n_state    = mhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == mhpq_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {r_m_count, r_m_min};
    assign m_axis_tuser  = r_m_flags;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mhpq_pkg::CAP_COUNT)
        else $error("Entry count exceeds capacity.");

    a_write_in_sift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == mhpq_pkg::ST_UP || r_state == mhpq_pkg::ST_DN))
        else $error("Memory written outside a sift.");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CW'(wr_addr) < r_count))
        else $error("Memory write beyond the held entries.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("Both error flags set on one result.");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == mhpq_pkg::REQ_INSERT
         && r_count < mhpq_pkg::CAP_COUNT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("Accepted insert did not grow the heap.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the min-heap priority queue: a scoreboard class keeps its own heap and
// checks every result transfer, while a plain task drives requests with random idling.
// Depends on mhpq_pkg and min_heap_priority_queue_top.
module tb_top;

    localparam int DIRECTED_ITEMS = 16;
    localparam int RANDOM_ITEMS   = 900;
    localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
    localparam int QUIET_LIMIT    = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NUM_SEGMENTS   = 6;
    localparam int SEG_LEN [NUM_SEGMENTS]     = '{100, 200, 200, 100, 150, 150};
    localparam int SEG_INSERT [NUM_SEGMENTS]  = '{50, 90, 10, 50, 90, 10};
    localparam int SEND_IDLE [3] = '{27, 76, 0};
    localparam int RECV_IDLE [3] = '{76, 27, 0};

    typedef logic signed [mhpq_pkg::DATA_WIDTH-1:0] t_key;

    typedef struct packed {
        t_key                       min_value;
        logic [mhpq_pkg::CNT_W-1:0] entry_count;
        logic                       empty_error;
        logic                       full_error;
    } t_outcome;

    class heap_scoreboard;
        t_key        keys [mhpq_pkg::CAPACITY];
        int unsigned held;
        t_outcome    outcomes [$];
        int unsigned mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return outcomes.size();
        endfunction

        function void note_request(input logic req, input t_key val);
            t_outcome    res;
            int unsigned pos;
            int unsigned up;
            int unsigned kid;
            t_key        moving;
            res = '0;
            if (req == mhpq_pkg::REQ_INSERT) begin
                if (held >= mhpq_pkg::CAPACITY) begin
                    res.full_error = 1'b1;
                end else begin
                    pos = held;
                    held++;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!(keys[up] > val))
                            break;
                        keys[pos] = keys[up];
                        pos = up;
                    end
                    keys[pos] = val;
                end
            end else begin
                if (held == 0) begin
                    res.empty_error = 1'b1;
                end else begin
                    res.min_value = keys[0];
                    held--;
                    moving = keys[held];
                    pos = 0;
                    forever begin
                        kid = 2 * pos + 1;
                        if (kid >= held)
                            break;
                        if (kid + 1 < held && keys[kid] > keys[kid + 1])
                            kid = kid + 1;
                        if (!(moving > keys[kid]))
                            break;
                        keys[pos] = keys[kid];
                        pos = kid;
                    end
                    keys[pos] = moving;
                end
            end
            res.entry_count = held[mhpq_pkg::CNT_W-1:0];
            outcomes.push_back(res);
        endfunction

        function void check_result(input logic [39:0] data, input logic [1:0] user);
            t_outcome got;
            t_outcome want;
            got.min_value   = data[31:0];
            got.entry_count = data[39:32];
            got.empty_error = user[0];
            got.full_error  = user[1];
            if (outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result transfer: min %0d count %0d empty %0b full %0b",
                             got.min_value, got.entry_count, got.empty_error, got.full_error);
                return;
            end
            want = outcomes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("Mismatch: expected min %0d count %0d empty %0b full %0b, ",
                           want.min_value, want.entry_count, want.empty_error,
                           want.full_error);
                    $display("got min %0d count %0d empty %0b full %0b",
                             got.min_value, got.entry_count, got.empty_error,
                             got.full_error);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    t_key        s_axis_tdata;   // [31:0] value
    logic        s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] min_value, [39:32] entry_count
    logic [1:0]  m_axis_tuser;   // [0] empty_error, [1] full_error

    heap_scoreboard heap_book;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             sent;
    int             quiet_cycles;

    min_heap_priority_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_key random_key();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return t_key'($urandom_range(0, 16)) - 8;
            default: return t_key'($urandom());
        endcase
    endfunction

    // The idling mix follows the stage of the run the next request falls in.
    task automatic send_request(input logic req, input t_key val);
        send_idle_pct = SEND_IDLE[(sent * 3) / TOTAL_ITEMS];
        recv_idle_pct = RECV_IDLE[(sent * 3) / TOTAL_ITEMS];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        heap_book.note_request(req, val);
        sent++;
    endtask

    initial begin
        heap_book      = new();
        sent           = 0;
        send_idle_pct  = SEND_IDLE[0];
        recv_idle_pct  = RECV_IDLE[0];
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mhpq_pkg::REQ_INSERT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Removal from an empty heap, key extremes, a tie, then drain past empty.
        send_request(mhpq_pkg::REQ_REMOVE, 32'h1234_5678);
        send_request(mhpq_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send_request(mhpq_pkg::REQ_INSERT, 32'h8000_0000);
        send_request(mhpq_pkg::REQ_INSERT, '0);
        send_request(mhpq_pkg::REQ_INSERT, '1);
        send_request(mhpq_pkg::REQ_INSERT, 5);
        send_request(mhpq_pkg::REQ_INSERT, 5);
        send_request(mhpq_pkg::REQ_INSERT, -5);
        repeat (DIRECTED_ITEMS - 8)
            send_request(mhpq_pkg::REQ_REMOVE, t_key'($urandom()));

        // Segments cycle twice through balanced, insert-heavy and remove-heavy request mixes.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            repeat (SEG_LEN[seg]) begin
                if ($urandom_range(0, 99) < SEG_INSERT[seg])
                    send_request(mhpq_pkg::REQ_INSERT, random_key());
                else
                    send_request(mhpq_pkg::REQ_REMOVE, t_key'($urandom()));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (heap_book.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (heap_book.mismatches == 0 && heap_book.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                heap_book.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
